/* rtl/core/quadrature_encoder_emulator_defines.svh */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator assertion macros
// Shared property macros for the encoder emulator RTL.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_EMULATOR_DEFINES_SVH
`define QUADRATURE_ENCODER_EMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QEE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QEE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

// Fixed-latency implication, disabled while reset is asserted.
`define QEE_ASSERT_LAT(lbl, clk_s, rstn_s, ante, lat, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> ##lat (cons)) \
    else $error(msg);

`endif

/* rtl/core/qee_pkg.sv */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator package
// Shared types, constants and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qee_pkg;

  localparam int unsigned STEPS_PER_TURN_DEF = 200;
  localparam logic [31:0] CLOCK_RATE_RST = 32'd5000000;

  // The period is clock_rate / (4 * mag), done as (clock_rate >> 2) / mag.
  localparam int unsigned DIVIDEND_W = 30;
  localparam int unsigned DIVISOR_W  = 8;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        tick;
    logic        set_dir;
    logic        dir;
    logic        load_phase;
    logic [1:0]  phase_seed;
    logic        clr_period;
    logic        load_period;
    logic [31:0] period;
  } phase_ctl_t;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic dir;
  } phase_sts_t;

  // Phase picked for a small move: ((pos mod 10) * 10) / 25. The quotient by
  // ten uses a reciprocal multiply that is exact for all 8-bit values.
  function automatic logic [1:0] phase_seed(input logic [7:0] pos);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  quo_x10;
    logic [3:0]  rem;
    prod    = 16'(pos) * 16'd205;
    quo     = prod[15:11];
    quo_x10 = 8'(quo) * 8'd10;
    rem     = 4'(pos - quo_x10);
    if (rem >= 4'd8) begin
      return 2'd3;
    end else if (rem >= 4'd5) begin
      return 2'd2;
    end else if (rem >= 4'd3) begin
      return 2'd1;
    end else begin
      return 2'd0;
    end
  endfunction

  // Each phase moves exactly one of the two lines.
  function automatic logic [1:0] apply_edge(input logic [1:0] ph, input logic [1:0] ab);
    logic [1:0] res;
    res = ab;
    case (ph)
      2'd0:    res[1] = 1'b0;
      2'd1:    res[0] = 1'b1;
      2'd2:    res[1] = 1'b1;
      2'd3:    res[0] = 1'b0;
      default: res = ab;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qee_divider.sv */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator serial divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qee_divider (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire [qee_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire [qee_pkg::DIVISOR_W-1:0]      divisor,
  output logic                              busy,
  output logic                              done,
  output logic [qee_pkg::DIVIDEND_W-1:0]    quotient
);

  logic [qee_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [qee_pkg::DIVIDEND_W-1:0] shf_r, shf_nxt;
  logic [qee_pkg::DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [qee_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [qee_pkg::DIVISOR_W:0]    trial;
  logic [qee_pkg::DIVISOR_W:0]    diff;
  logic                           fits;

  // The dividend leaves the shift register at the top while quotient bits
  // enter at the bottom.
  assign trial = {rem_r, shf_r[qee_pkg::DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      shf_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = qee_pkg::DIV_CNT_W'(qee_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[qee_pkg::DIVISOR_W-1:0] : trial[qee_pkg::DIVISOR_W-1:0];
      shf_nxt = {shf_r[qee_pkg::DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == qee_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = shf_r;

endmodule

`default_nettype wire

/* rtl/core/qee_phase_gen.sv */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator phase generator
// Holds the edge period, tick counter, phase, direction and line levels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qee_phase_gen (
  input  wire                 clk,
  input  wire                 rst_n,
  input  qee_pkg::phase_ctl_t ctl,
  output qee_pkg::phase_sts_t sts
);

  logic [31:0] period_r, period_nxt;
  logic [31:0] tick_cnt_r, tick_cnt_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  lines_r, lines_nxt;
  logic        dir_r, dir_nxt;
  logic [31:0] cnt_inc;

  assign cnt_inc = tick_cnt_r + 32'd1;

  always_comb begin
    period_nxt   = period_r;
    tick_cnt_nxt = tick_cnt_r;
    phase_nxt    = phase_r;
    lines_nxt    = lines_r;
    dir_nxt      = dir_r;
    if (ctl.set_dir) begin
      dir_nxt = ctl.dir;
    end
    if (ctl.clr_period) begin
      period_nxt = '0;
    end
    if (ctl.load_period) begin
      period_nxt = ctl.period;
    end
    if (ctl.load_phase) begin
      phase_nxt = ctl.phase_seed;
      lines_nxt = qee_pkg::apply_edge(ctl.phase_seed, lines_r);
    end
    // A stopped encoder (zero period) ignores ticks entirely.
    if (ctl.tick && (period_r != '0)) begin
      if (cnt_inc >= period_r) begin
        tick_cnt_nxt = '0;
        phase_nxt    = dir_r ? phase_r + 2'd1 : phase_r - 2'd1;
        lines_nxt    = qee_pkg::apply_edge(phase_nxt, lines_r);
      end else begin
        tick_cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= '0;
      tick_cnt_r <= '0;
      phase_r    <= '0;
      lines_r    <= '0;
      dir_r      <= 1'b0;
    end else begin
      period_r   <= period_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      phase_r    <= phase_nxt;
      lines_r    <= lines_nxt;
      dir_r      <= dir_nxt;
    end
  end

  // Levels as they stand after this cycle's update, so a result can be
  // registered in the same cycle.
  assign sts.line_a = lines_nxt[1];
  assign sts.line_b = lines_nxt[0];
  assign sts.dir    = dir_nxt;

endmodule

`default_nettype wire

/* rtl/core/quadrature_encoder_emulator.sv */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator
// Turns knob positions and clock ticks into quadrature A/B line levels.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per transfer: a tick (opcode 1) or a
//   position update (opcode 0) with knob position and button level. Every
//   item yields exactly one result transfer with lines A and B, the latched
//   button level and the current direction.
//   Ticks, zero moves and moves of one or two steps finish in the accept
//   cycle and load the output register at the accepting edge, so the result
//   can transfer in the next cycle and such items go back to back at one per
//   cycle while the receiver keeps up. A larger move runs the serial divider
//   for the edge period, one quotient bit per cycle over 30 bits: the input
//   stalls until the quotient is loaded as the period and the result is
//   registered, and the next item is taken at the edge the result can transfer.
//   The block takes a new item while a result still waits in the output
//   register; that item's result is held back until the register frees.
//   A stalled result holds its payload. Reset clears the state, sets the
//   button level high and loads clock_rate with 5000000. The cfg port
//   writes clock_rate and is to be used only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_encoder_emulator_defines.svh"

module quadrature_encoder_emulator #(
  parameter int unsigned STEPS_PER_TURN = qee_pkg::STEPS_PER_TURN_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [31:0] cfg_wdata,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_opcode,
  input  wire [7:0]  in_knob_position,
  input  wire        in_button_level,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_line_a,
  output logic       out_line_b,
  output logic       out_button_out,
  output logic       out_turning_up
);

  localparam logic signed [10:0] TURN_X2  = 11'(STEPS_PER_TURN);
  localparam logic signed [9:0]  TURN_D   = 10'(STEPS_PER_TURN);
  localparam int unsigned        DIV_LAT  = qee_pkg::DIV_STEPS + 1;

  qee_pkg::state_t     state_r, state_nxt;
  logic [31:0]         clock_rate_r;
  logic [7:0]          last_pos_r, last_pos_nxt;
  logic                button_r, button_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_a_r, out_b_r, out_btn_r, out_dir_r;
  logic                out_load;
  logic                in_fire;
  logic                slot_free;
  logic                item_done;
  logic signed [9:0]   diff_raw;
  logic signed [10:0]  diff_x2;
  logic signed [9:0]   diff;
  logic [9:0]          diff_abs;
  logic [7:0]          mag;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [qee_pkg::DIVIDEND_W-1:0] div_quo;
  qee_pkg::phase_ctl_t ctl;
  qee_pkg::phase_sts_t sts;

  // Signed move, wrapped into about half a turn either way.
  assign diff_raw = $signed({2'b00, in_knob_position}) - $signed({2'b00, last_pos_r});
  assign diff_x2  = {diff_raw, 1'b0};

  always_comb begin
    if (diff_x2 < -TURN_X2) begin
      diff = diff_raw + TURN_D;
    end else if (diff_x2 > TURN_X2) begin
      diff = diff_raw - TURN_D;
    end else begin
      diff = diff_raw;
    end
  end

  assign diff_abs = diff[9] ? 10'(-diff) : 10'(diff);
  assign mag      = diff_abs[7:0];

  assign in_stall  = (state_r != qee_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    last_pos_nxt = last_pos_r;
    button_nxt   = button_r;
    ctl          = '0;
    div_start    = 1'b0;
    item_done    = 1'b0;
    case (state_r)
      qee_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode) begin
            ctl.tick  = 1'b1;
            item_done = 1'b1;
          end else begin
            button_nxt = in_button_level;
            if (diff == '0) begin
              ctl.clr_period = 1'b1;
              item_done      = 1'b1;
            end else begin
              ctl.set_dir  = 1'b1;
              ctl.dir      = !diff[9];
              last_pos_nxt = in_knob_position;
              if (mag <= 8'd2) begin
                ctl.load_phase = 1'b1;
                ctl.phase_seed = qee_pkg::phase_seed(last_pos_r);
                ctl.clr_period = 1'b1;
                item_done      = 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = qee_pkg::ST_DIV;
              end
            end
          end
        end
      end
      qee_pkg::ST_DIV: begin
        if (div_done) begin
          ctl.load_period = 1'b1;
          ctl.period      = 32'(div_quo);
          item_done       = 1'b1;
        end
      end
      qee_pkg::ST_EMIT: begin
        item_done = 1'b1;
      end
      default: begin
        state_nxt = qee_pkg::ST_IDLE;
      end
    endcase
    // A finished item waits in ST_EMIT while the output register holds a stalled result.
    if (item_done) begin
      state_nxt = slot_free ? qee_pkg::ST_IDLE : qee_pkg::ST_EMIT;
    end
  end

  assign out_load = item_done && slot_free;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  qee_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_rate_r[31:2]),
    .divisor  (mag),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  qee_phase_gen u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qee_pkg::ST_IDLE;
      clock_rate_r <= qee_pkg::CLOCK_RATE_RST;
      last_pos_r   <= '0;
      button_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pos_r  <= last_pos_nxt;
      button_r    <= button_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clock_rate_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_a_r   <= sts.line_a;
      out_b_r   <= sts.line_b;
      out_btn_r <= button_nxt;
      out_dir_r <= sts.dir;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_a     = out_a_r;
  assign out_line_b     = out_b_r;
  assign out_button_out = out_btn_r;
  assign out_turning_up = out_dir_r;

  `QEE_ASSERT_LAT(a_div_latency, clk, rst_n, div_start, DIV_LAT, div_done, "divider missed its fixed latency")
  `QEE_ASSERT_NOW(a_no_accept_in_div, clk, rst_n, div_busy, in_stall, "input open while divider runs")
  `QEE_ASSERT_NEXT(a_emit_delivers, clk, rst_n, (state_r == qee_pkg::ST_EMIT) && slot_free, out_valid_r, "held result was not registered")

endmodule

`default_nettype wire

/* tb/sv/quadrature_encoder_emulator_test.sv */
// ---------------------------------------------------------------------------
// Quadrature encoder emulator testbench
// Drives position updates and clock ticks into the emulator and checks
// every result transfer against a cycle-free model of the encoder state.
// It runs several clock_rate settings and puts random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadrature_encoder_emulator_test;

  localparam int STEPS = int'(qee_pkg::STEPS_PER_TURN_DEF);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic button;
    logic turning_up;
  } line_levels_t;

  class encoder_scoreboard;
    bit [31:0]    clock_rate;
    logic [7:0]   last_pos;
    logic [1:0]   phase;
    logic         turning_up;
    logic         line_a;
    logic         line_b;
    logic         button;
    bit [31:0]    period;
    bit [31:0]    tick_count;
    line_levels_t expected_lines[$];
    int           mismatches;
    int           results_seen;

    function new();
      clock_rate   = qee_pkg::CLOCK_RATE_RST;
      last_pos     = '0;
      phase        = '0;
      turning_up   = 1'b0;
      line_a       = 1'b0;
      line_b       = 1'b0;
      button       = 1'b1;
      period       = '0;
      tick_count   = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_clock_rate(bit [31:0] rate);
      clock_rate = rate;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // Each phase moves exactly one line.
    function void drive_edge();
      case (phase)
        2'd0: line_a = 1'b0;
        2'd1: line_b = 1'b1;
        2'd2: line_a = 1'b1;
        2'd3: line_b = 1'b0;
      endcase
    endfunction

    function void note_item(opcode_e op, logic [7:0] knob, logic btn);
      int        d;
      bit [31:0] mag;
      if (op == OP_UPDATE) begin
        d = int'(knob) - int'(last_pos);
        if (2 * d < -STEPS) begin
          d += STEPS;
        end else if (2 * d > STEPS) begin
          d -= STEPS;
        end
        if (d == 0) begin
          period = '0;
        end else begin
          mag        = (d < 0) ? -d : d;
          turning_up = (d > 0);
          if (mag <= 2) begin
            phase = 2'(((int'(last_pos) % 10) * 10) / 25);
            drive_edge();
            period = '0;
          end else begin
            period = clock_rate / (4 * mag);
          end
          last_pos = knob;
        end
        button = btn;
      end else if (period != 0) begin
        tick_count = tick_count + 1;
        // A period shortened below the running count fires on the next tick.
        if (tick_count >= period) begin
          tick_count = '0;
          phase      = turning_up ? phase + 2'd1 : phase - 2'd1;
          drive_edge();
        end
      end
      expected_lines.push_back('{line_a, line_b, button, turning_up});
    endfunction

    function void check_lines(logic a, logic b, logic btn, logic up);
      line_levels_t want;
      results_seen++;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing expected: a=%0b b=%0b button=%0b up=%0b",
                   results_seen, a, b, btn, up);
        end
        return;
      end
      want = expected_lines.pop_front();
      if (a !== want.line_a || b !== want.line_b || btn !== want.button ||
          up !== want.turning_up) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected a=%0b b=%0b button=%0b up=%0b, got a=%0b b=%0b %s",
                   results_seen, want.line_a, want.line_b, want.button, want.turning_up,
                   a, b, $sformatf("button=%0b up=%0b", btn, up));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [7:0]  in_knob_position;
  logic        in_button_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_line_a;
  logic        out_line_b;
  logic        out_button_out;
  logic        out_turning_up;

  encoder_scoreboard sb = new();
  int                send_calm = 0;

  quadrature_encoder_emulator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_knob_position (in_knob_position),
    .in_button_level  (in_button_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_a       (out_line_a),
    .out_line_b       (out_line_b),
    .out_button_out   (out_button_out),
    .out_turning_up   (out_turning_up)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_lines(out_line_a, out_line_b, out_button_out, out_turning_up);
    end
  end

  // Mostly short gaps, a few long ones, and calm stretches with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 40);
      return 0;
    end else if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // Receiver side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int run;
    int hold;
    int calm;
    bit long_hold_done;
    out_stall      = 1'b0;
    calm           = 0;
    long_hold_done = 1'b0;
    forever begin
      if (!long_hold_done && sb.results_seen >= 150) begin
        long_hold_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (399) @(negedge clk);
      end
      run = $urandom_range(1, 6);
      @(negedge clk);
      out_stall <= 1'b0;
      repeat (run - 1) @(negedge clk);
      hold = pick_gap(calm);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  task automatic send_item(opcode_e op, logic [7:0] knob, logic btn);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_knob_position <= knob;
    in_button_level  <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, knob, btn);
  endtask

  task automatic update(logic [7:0] knob, logic btn);
    send_item(OP_UPDATE, knob, btn);
  endtask

  task automatic tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_clock_rate(logic [31:0] rate);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_clock_rate(rate);
  endtask

  // Most items are ticks and well-formed moves relative to the last position.
  task automatic random_item();
    int         sel;
    int         delta;
    logic [7:0] knob;
    sel  = $urandom_range(0, 99);
    knob = 8'($urandom_range(0, 255));
    if (sel < 58) begin
      send_item(OP_TICK, knob, 1'($urandom));
    end else begin
      if (sel < 70 || sel >= 75 && sel < 94) begin
        delta = (sel < 70) ? $urandom_range(1, 2) : $urandom_range(3, STEPS / 2);
        if ($urandom_range(0, 1) == 1) begin
          delta = -delta;
        end
        knob = 8'((int'(sb.last_pos) + STEPS + delta) % STEPS);
      end else if (sel < 75) begin
        knob = sb.last_pos;
      end
      send_item(OP_UPDATE, knob, 1'($urandom));
    end
  endtask

  initial begin
    logic [31:0] rates[6];
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_opcode        = OP_TICK;
    in_knob_position = '0;
    in_button_level  = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A zero move, small moves from every phase seed, wrap in both directions,
    // a half-turn move each way and positions past the end of the turn.
    update(8'd0, 1'b0);
    update(8'd1, 1'b1);
    update(8'd3, 1'b1);
    update(8'd2, 1'b1);
    update(8'd199, 1'b1);
    tick();
    tick();
    update(8'd0, 1'b1);
    update(8'd100, 1'b0);
    update(8'd0, 1'b1);
    update(8'd255, 1'b1);
    update(8'd200, 1'b0);
    update(8'd128, 1'b0);
    update(8'd8, 1'b1);
    update(8'd7, 1'b1);
    update(8'd5, 1'b1);
    update(8'd6, 1'b1);
    send_item(OP_TICK, 8'hFF, 1'b0);
    wait_idle();

    // The tick count left over from above already reaches the new short period.
    write_clock_rate(32'd24);
    update(8'd9, 1'b1);
    tick();
    tick();
    tick();
    update(8'd39, 1'b0);
    tick();
    wait_idle();

    rates = '{32'd1, 32'd24, 32'd100, 32'd400, 32'hFFFF_FFFF,
              32'($urandom_range(12, 3000))};
    foreach (rates[i]) begin
      write_clock_rate(rates[i]);
      for (int n = 0; n < 80; n++) begin
        if (i == 3 && n == 40) begin
          wait_idle();
        end
        random_item();
      end
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
